>>> rtl/core/cws_pkg.sv
// Shared types and constants for the congestion window sender.
// Used by every module of the block but cws_ram; depends on nothing else.
package cws_pkg;

    // Fixed field widths of the request, result and configuration fields.
    localparam int FS_W   = 23;
    localparam int SEQ_W  = 12;
    localparam int LEN_W  = 11;
    localparam int WIN_W  = 7;
    localparam int BASE_W = 13;
    localparam int KIND_W = 3;

    // The slow start threshold after reset.
    localparam logic [WIN_W-1:0] THR_RESET = 7'd16;

    // Configuration register indexes.
    localparam logic REG_FILE_SIZE = 1'b0;
    localparam logic REG_INIT_THR  = 1'b1;

    // Request type codes on the input channel.
    localparam logic [1:0] REQ_SEND    = 2'd0;
    localparam logic [1:0] REQ_ACK     = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_DATA = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FAIL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IGN  = 3'd5;

    // Packet status codes held in the status memory.
    localparam logic [1:0] ST_UNSENT = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_ACKED  = 2'd2;

    // Decoded request as it travels from the front to the back.
    typedef enum logic [1:0] {
        CMD_SEND,
        CMD_ACK,
        CMD_TIMEOUT,
        CMD_NONE
    } cws_cmd_kind_t;

    typedef struct packed {
        cws_cmd_kind_t     cmd;
        logic [SEQ_W-1:0]  aseq;
    } cws_cmd_t;

    // Threshold load request from the configuration port.
    typedef struct packed {
        logic              load;
        logic [WIN_W-1:0]  value;
    } cws_thr_ld_t;

    // Sequencer states of the back part.
    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SEND_RD,
        BK_SEND_EMIT,
        BK_ACK_CLOSE
    } cws_bk_state_t;

endpackage

>>> rtl/core/cws_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; no package needed.
module cws_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/cws_front.sv
// Front part: configuration registers, packet total divider and request decode.
// Depends on cws_pkg.
module cws_front #(
    parameter int PACKET_BYTES = 1024,
    parameter int MAX_PACKETS  = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic                                   wr_index,
    input  logic [cws_pkg::FS_W-1:0]               wr_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             req_type,
    input  logic [cws_pkg::SEQ_W-1:0]              ack_seq,
    input  logic                                   q_full,
    input  logic                                   clearing,
    output logic                                   q_push,
    output cws_pkg::cws_cmd_t                      q_wdata,
    output cws_pkg::cws_thr_ld_t                   thr_ld,
    output logic [$clog2(MAX_PACKETS+1)-1:0]       total,
    output logic [$clog2(PACKET_BYTES+1)-1:0]      last_len
);

    localparam int BW  = $clog2(MAX_PACKETS + 1);
    localparam int PBW = $clog2(PACKET_BYTES + 1);
    // Scaled reciprocal of the packet size: the product shifted down by RSH
    // is the exact quotient for every value the file size register can hold.
    localparam int RSH = cws_pkg::FS_W + $clog2(PACKET_BYTES);
    localparam int MW  = cws_pkg::FS_W + 1;
    localparam int PW  = cws_pkg::FS_W + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << RSH) + PACKET_BYTES - 1) / PACKET_BYTES;

    logic                       busy_reg, busy_next;
    logic                       sub_reg, sub_next;
    logic                       fin_reg, fin_next;
    logic [cws_pkg::FS_W-1:0]   fs_reg, fs_next;
    logic [PBW-1:0]             rem_reg, rem_next;
    logic [cws_pkg::FS_W-1:0]   quo_reg, quo_next;
    logic [BW-1:0]              total_reg, total_next;
    logic [PBW-1:0]             len_reg, len_next;

    logic [PW-1:0]              prod;
    logic [cws_pkg::FS_W-1:0]   quo_bytes;
    logic [cws_pkg::FS_W:0]     ceil_q;
    logic                       sat;

    // Quotient, then remainder, then the rounded and saturated packet total,
    // one step per cycle.
    assign prod      = PW'(fs_reg) * PW'(RECIP);
    assign quo_bytes = quo_reg * cws_pkg::FS_W'(PACKET_BYTES);
    assign ceil_q    = {1'b0, quo_reg} + (cws_pkg::FS_W+1)'(rem_reg != '0);
    assign sat       = ceil_q > (cws_pkg::FS_W+1)'(MAX_PACKETS);

    always_comb
    begin
        busy_next  = 1'b0;
        sub_next   = 1'b0;
        fin_next   = 1'b0;
        fs_next    = fs_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        total_next = total_reg;
        len_next   = len_reg;
        if (wr_en && wr_index == cws_pkg::REG_FILE_SIZE)
        begin
            busy_next = 1'b1;
            fs_next   = wr_data;
        end
        else if (busy_reg)
        begin
            quo_next = cws_pkg::FS_W'(prod >> RSH);
            sub_next = 1'b1;
        end
        else if (sub_reg)
        begin
            rem_next = PBW'(fs_reg - quo_bytes);
            fin_next = 1'b1;
        end
        else if (fin_reg)
        begin
            total_next = sat ? BW'(MAX_PACKETS) : ceil_q[BW-1:0];
            len_next   = (sat || rem_reg == '0) ? PBW'(PACKET_BYTES) : rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            sub_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            total_reg <= '0;
            len_reg   <= PBW'(PACKET_BYTES);
        end
        else
        begin
            busy_reg  <= busy_next;
            sub_reg   <= sub_next;
            fin_reg   <= fin_next;
            total_reg <= total_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fs_reg  <= fs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign in_stall = busy_reg || sub_reg || fin_reg || q_full || clearing;
    assign q_push   = in_valid && !in_stall;

    always_comb
    begin
        q_wdata.aseq = ack_seq;
        case (req_type)
            cws_pkg::REQ_SEND:    q_wdata.cmd = cws_pkg::CMD_SEND;
            cws_pkg::REQ_ACK:     q_wdata.cmd = cws_pkg::CMD_ACK;
            cws_pkg::REQ_TIMEOUT: q_wdata.cmd = cws_pkg::CMD_TIMEOUT;
            default:              q_wdata.cmd = cws_pkg::CMD_NONE;
        endcase
    end

    assign thr_ld.load  = wr_en && wr_index == cws_pkg::REG_INIT_THR;
    assign thr_ld.value = wr_data[cws_pkg::WIN_W-1:0];
    assign total        = total_reg;
    assign last_len     = len_reg;

endmodule

>>> rtl/core/cws_queue.sv
// Two-entry command queue between the front and the back.
// Depends on cws_pkg.
module cws_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cws_pkg::cws_cmd_t wdata,
    input  logic              pop,
    output cws_pkg::cws_cmd_t rdata,
    output logic              not_empty,
    output logic              full
);

    cws_pkg::cws_cmd_t entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign not_empty = count_reg != 2'd0;
    assign full      = count_reg == 2'd2;
    assign rdata     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/core/cws_back.sv
// Back part: window state, status memory sequencing and the result register.
// Depends on cws_pkg and cws_ram.
module cws_back #(
    parameter int PACKET_BYTES = 1024,
    parameter int MAX_PACKETS  = 4096,
    parameter int MAX_WINDOW   = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  cws_pkg::cws_cmd_t                      q_data,
    output logic                                   q_pop,
    input  logic [$clog2(MAX_PACKETS+1)-1:0]       total,
    input  logic [$clog2(PACKET_BYTES+1)-1:0]      last_len,
    input  cws_pkg::cws_thr_ld_t                   thr_ld,
    output logic                                   clearing,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [cws_pkg::KIND_W-1:0]             kind,
    output logic [cws_pkg::SEQ_W-1:0]              seq,
    output logic [cws_pkg::LEN_W-1:0]              length,
    output logic                                   resend,
    output logic                                   last,
    output logic [cws_pkg::WIN_W-1:0]              window,
    output logic [cws_pkg::WIN_W-1:0]              threshold,
    output logic [cws_pkg::BASE_W-1:0]             next_start
);

    localparam int BW  = $clog2(MAX_PACKETS + 1);
    localparam int AW  = $clog2(MAX_PACKETS);
    localparam int PBW = $clog2(PACKET_BYTES + 1);
    localparam int CW  = (BW > cws_pkg::BASE_W) ? BW : cws_pkg::BASE_W;
    localparam int WW  = cws_pkg::WIN_W;

    cws_pkg::cws_bk_state_t state_reg, state_next;

    logic [CW-1:0]   base_reg, base_next;
    logic [WW-1:0]   win_reg, win_next;
    logic [WW-1:0]   thr_reg, thr_next;
    logic [WW-1:0]   emitted_reg, emitted_next;
    logic [WW-1:0]   acks_reg, acks_next;
    logic [CW-1:0]   han_reg, han_next;
    logic            open_reg, open_next;
    logic [WW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [cws_pkg::KIND_W-1:0] ckind_reg, ckind_next;

    logic            ov_reg, ov_next;
    logic [cws_pkg::KIND_W-1:0] o_kind_reg, o_kind_next;
    logic [cws_pkg::SEQ_W-1:0]  o_seq_reg, o_seq_next;
    logic [cws_pkg::LEN_W-1:0]  o_len_reg, o_len_next;
    logic            o_rs_reg, o_rs_next;
    logic            o_last_reg, o_last_next;
    logic [WW-1:0]   o_win_reg, o_win_next;
    logic [WW-1:0]   o_thr_reg, o_thr_next;
    logic [cws_pkg::BASE_W-1:0] o_ns_reg, o_ns_next;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [1:0]      ram_wdata, ram_rdata;

    logic            out_free, push;
    logic [CW-1:0]   total_ext, id, end_w, aseq_ext, aseq_inc, ack_han, fu_to;
    logic            ack_ok, closes, take, send_go, ack_close, last_d;
    logic [WW-1:0]   acks_inc, half, thr_fail, win_grow;
    logic [WW:0]     grow8;

    assign out_free  = !ov_reg || !out_stall;
    assign total_ext = CW'(total);
    assign id        = base_reg + CW'(idx_reg);
    assign end_w     = base_reg + CW'(emitted_reg);
    assign aseq_ext  = CW'(q_data.aseq);
    assign aseq_inc  = aseq_ext + 1'b1;
    assign ack_ok    = open_reg && aseq_ext < total_ext;
    assign ack_han   = (aseq_inc > han_reg) ? aseq_inc : han_reg;
    assign acks_inc  = acks_reg + 1'b1;
    assign closes    = acks_inc >= emitted_reg;
    assign fu_to     = (han_reg != '0) ? han_reg : base_reg;
    assign half      = win_reg >> 1;
    assign thr_fail  = (half == '0) ? WW'(1) : half;
    assign grow8     = (win_reg < thr_reg) ? {win_reg, 1'b0} : {1'b0, win_reg} + 1'b1;
    assign win_grow  = (grow8 > (WW+1)'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : grow8[WW-1:0];
    assign last_d    = (idx_reg + 1'b1 >= win_reg) || (id + 1'b1 >= total_ext);

    assign take      = state_reg == cws_pkg::BK_IDLE && q_valid && out_free;
    assign send_go   = take && q_data.cmd == cws_pkg::CMD_SEND && !open_reg
                       && base_reg < total_ext;
    assign ack_close = take && q_data.cmd == cws_pkg::CMD_ACK && ack_ok && closes;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cws_pkg::BK_CLEAR:
            begin
                if (clr_reg == AW'(MAX_PACKETS - 1))
                begin
                    state_next = cws_pkg::BK_IDLE;
                end
            end
            cws_pkg::BK_IDLE:
            begin
                if (send_go)
                begin
                    state_next = cws_pkg::BK_SEND_RD;
                end
                else if (ack_close)
                begin
                    state_next = cws_pkg::BK_ACK_CLOSE;
                end
            end
            cws_pkg::BK_SEND_RD:
            begin
                state_next = cws_pkg::BK_SEND_EMIT;
            end
            cws_pkg::BK_SEND_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_d ? cws_pkg::BK_IDLE : cws_pkg::BK_SEND_RD;
                end
            end
            cws_pkg::BK_ACK_CLOSE:
            begin
                if (out_free)
                begin
                    state_next = cws_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = cws_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath, memory control and results.
    always_comb
    begin
        base_next    = base_reg;
        win_next     = win_reg;
        thr_next     = thr_ld.load ? thr_ld.value : thr_reg;
        emitted_next = emitted_reg;
        acks_next    = acks_reg;
        han_next     = han_reg;
        open_next    = open_reg;
        idx_next     = idx_reg;
        clr_next     = clr_reg;
        ckind_next   = ckind_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = id[AW-1:0];
        ram_wdata    = cws_pkg::ST_WAIT;
        ram_re       = 1'b0;
        ram_raddr    = id[AW-1:0];
        push         = 1'b0;
        o_kind_next  = cws_pkg::KIND_IGN;
        o_seq_next   = '0;
        o_len_next   = '0;
        o_rs_next    = 1'b0;
        o_last_next  = 1'b1;
        case (state_reg)
            cws_pkg::BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = cws_pkg::ST_UNSENT;
                clr_next  = clr_reg + 1'b1;
            end
            cws_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    q_pop = 1'b1;
                    case (q_data.cmd)
                        cws_pkg::CMD_SEND:
                        begin
                            if (open_reg)
                            begin
                                push = 1'b1;
                            end
                            else if (base_reg >= total_ext)
                            begin
                                push        = 1'b1;
                                o_kind_next = cws_pkg::KIND_DONE;
                            end
                            else
                            begin
                                idx_next  = '0;
                                acks_next = '0;
                                han_next  = '0;
                                open_next = 1'b1;
                            end
                        end
                        cws_pkg::CMD_ACK:
                        begin
                            push = 1'b1;
                            if (ack_ok)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = aseq_ext[AW-1:0];
                                ram_wdata   = cws_pkg::ST_ACKED;
                                han_next    = ack_han;
                                acks_next   = acks_inc;
                                o_kind_next = cws_pkg::KIND_ACK;
                                o_seq_next  = q_data.aseq;
                                if (closes)
                                begin
                                    o_last_next = 1'b0;
                                    open_next   = 1'b0;
                                    if (ack_han < end_w)
                                    begin
                                        base_next  = ack_han;
                                        thr_next   = thr_fail;
                                        win_next   = WW'(1);
                                        ckind_next = cws_pkg::KIND_FAIL;
                                    end
                                    else
                                    begin
                                        base_next  = end_w;
                                        win_next   = win_grow;
                                        ckind_next = cws_pkg::KIND_OK;
                                    end
                                end
                            end
                        end
                        cws_pkg::CMD_TIMEOUT:
                        begin
                            push = 1'b1;
                            if (open_reg)
                            begin
                                open_next   = 1'b0;
                                base_next   = fu_to;
                                thr_next    = thr_fail;
                                win_next    = WW'(1);
                                o_kind_next = cws_pkg::KIND_FAIL;
                            end
                        end
                        default:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            cws_pkg::BK_SEND_RD:
            begin
                ram_re = 1'b1;
            end
            cws_pkg::BK_SEND_EMIT:
            begin
                if (out_free)
                begin
                    push        = 1'b1;
                    ram_we      = 1'b1;
                    o_kind_next = cws_pkg::KIND_DATA;
                    o_seq_next  = id[cws_pkg::SEQ_W-1:0];
                    o_len_next  = (id + 1'b1 == total_ext)
                                  ? cws_pkg::LEN_W'(last_len)
                                  : cws_pkg::LEN_W'(PACKET_BYTES);
                    o_rs_next   = ram_rdata != cws_pkg::ST_UNSENT;
                    o_last_next = last_d;
                    idx_next    = idx_reg + 1'b1;
                    if (last_d)
                    begin
                        emitted_next = idx_reg + 1'b1;
                    end
                end
            end
            cws_pkg::BK_ACK_CLOSE:
            begin
                if (out_free)
                begin
                    push        = 1'b1;
                    o_kind_next = ckind_reg;
                end
            end
            default:
            begin
            end
        endcase
        o_win_next = win_next;
        o_thr_next = thr_next;
        o_ns_next  = base_next[cws_pkg::BASE_W-1:0];
        ov_next    = push || (ov_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cws_pkg::BK_CLEAR;
            base_reg    <= '0;
            win_reg     <= WW'(1);
            thr_reg     <= cws_pkg::THR_RESET;
            emitted_reg <= '0;
            acks_reg    <= '0;
            han_reg     <= '0;
            open_reg    <= 1'b0;
            idx_reg     <= '0;
            clr_reg     <= '0;
            ckind_reg   <= cws_pkg::KIND_OK;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            win_reg     <= win_next;
            thr_reg     <= thr_next;
            emitted_reg <= emitted_next;
            acks_reg    <= acks_next;
            han_reg     <= han_next;
            open_reg    <= open_next;
            idx_reg     <= idx_next;
            clr_reg     <= clr_next;
            ckind_reg   <= ckind_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            o_kind_reg <= o_kind_next;
            o_seq_reg  <= o_seq_next;
            o_len_reg  <= o_len_next;
            o_rs_reg   <= o_rs_next;
            o_last_reg <= o_last_next;
            o_win_reg  <= o_win_next;
            o_thr_reg  <= o_thr_next;
            o_ns_reg   <= o_ns_next;
        end
    end

    cws_ram #(
        .WIDTH (2),
        .DEPTH (MAX_PACKETS)
    ) u_status (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign clearing   = state_reg == cws_pkg::BK_CLEAR;
    assign out_valid  = ov_reg;
    assign kind       = o_kind_reg;
    assign seq        = o_seq_reg;
    assign length     = o_len_reg;
    assign resend     = o_rs_reg;
    assign last       = o_last_reg;
    assign window     = o_win_reg;
    assign threshold  = o_thr_reg;
    assign next_start = o_ns_reg;

    // The window always stays within one and the saturation limit.
    a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg != '0 && win_reg <= WW'(MAX_WINDOW))
        else $error("window out of range");

    // While a round is open and waiting, fewer acks than descriptors have been seen.
    a_acks_open: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg && state_reg == cws_pkg::BK_IDLE) |-> acks_reg < emitted_reg)
        else $error("open round has all its acks");

    // No request leaves the queue during the clearing pass.
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cws_pkg::BK_CLEAR |-> !q_pop)
        else $error("request taken during clearing");

    // After the last descriptor of a window the round is open with its count.
    a_send_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cws_pkg::BK_SEND_EMIT && out_free && last_d)
        |=> open_reg && emitted_reg != '0)
        else $error("round not open after send");

endmodule

>>> rtl/core/congestion_window_sender.sv
// Top level of the congestion window sender: slow start window control with
// go-back recovery. Instantiates cws_front, cws_queue and cws_back; uses cws_pkg.
//
// Usage. Requests enter on the input channel (in_valid, in_stall, req_type,
// ack_seq) and results leave on the output channel (out_valid, out_stall and
// the result fields). A request is taken when in_valid is high and in_stall is
// low; a result is taken when out_valid is high and out_stall is low. A send
// request that opens a round gives one data descriptor per packet of the
// window, an ack request one or two results, any other request one result;
// the last result of each request carries last.
// Timing. A request waits in a two-entry queue and the back takes one at a
// time. An ack, timeout or ignored request has its result registered when the
// back takes it; a round closing on an ack adds a second result from the
// close state once the output register is free. For a send the back reads
// each packet's status through a registered read ahead of its descriptor and
// takes no new request until the window is out. A file_size write holds
// in_stall high through the quotient, remainder and total steps of the
// reciprocal multiplication that works out the packet total; threshold writes
// take effect at once.
// Reset. After rst_n is released the status memory is cleared one entry a
// cycle over all MAX_PACKETS entries, with in_stall held high meanwhile.
// Stalls. A stalled result stays in the output register unchanged; the back
// waits, the queue fills and in_stall rises, so nothing is lost.
module congestion_window_sender #(
    parameter int PACKET_BYTES = 1024,
    parameter int MAX_PACKETS  = 4096,
    parameter int MAX_WINDOW   = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          wr_index,
    input  logic [cws_pkg::FS_W-1:0]      wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [cws_pkg::SEQ_W-1:0]     ack_seq,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cws_pkg::KIND_W-1:0]    kind,
    output logic [cws_pkg::SEQ_W-1:0]     seq,
    output logic [cws_pkg::LEN_W-1:0]     length,
    output logic                          resend,
    output logic                          last,
    output logic [cws_pkg::WIN_W-1:0]     window,
    output logic [cws_pkg::WIN_W-1:0]     threshold,
    output logic [cws_pkg::BASE_W-1:0]    next_start
);

    localparam int BW  = $clog2(MAX_PACKETS + 1);
    localparam int PBW = $clog2(PACKET_BYTES + 1);

    // Front to queue and back.
    logic                  q_push, q_pop, q_not_empty, q_full, clearing;
    cws_pkg::cws_cmd_t     q_wdata, q_rdata;
    cws_pkg::cws_thr_ld_t  thr_ld;
    logic [BW-1:0]         total;
    logic [PBW-1:0]        last_len;

    cws_front #(
        .PACKET_BYTES (PACKET_BYTES),
        .MAX_PACKETS  (MAX_PACKETS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .ack_seq  (ack_seq),
        .q_full   (q_full),
        .clearing (clearing),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .thr_ld   (thr_ld),
        .total    (total),
        .last_len (last_len)
    );

    // The queue lets the front keep taking requests while the back is busy.
    cws_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    cws_back #(
        .PACKET_BYTES (PACKET_BYTES),
        .MAX_PACKETS  (MAX_PACKETS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .total      (total),
        .last_len   (last_len),
        .thr_ld     (thr_ld),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .seq        (seq),
        .length     (length),
        .resend     (resend),
        .last       (last),
        .window     (window),
        .threshold  (threshold),
        .next_start (next_start)
    );

endmodule

>>> bench/congestion_window_sender_tb.sv
// Self-checking testbench for the congestion window sender: directed and random
// request streams against a behavioural window predictor. Depends on cws_pkg
// and the congestion_window_sender RTL only.
module congestion_window_sender_tb;

    localparam int PKT_BYTES = 1024;
    localparam int PKT_MAX   = 4096;
    localparam int WIN_MAX   = 64;

    // One expected or observed result of the block.
    typedef struct packed {
        logic [cws_pkg::KIND_W-1:0] kind;
        logic [cws_pkg::SEQ_W-1:0]  seq;
        logic [cws_pkg::LEN_W-1:0]  length;
        logic                       resend;
        logic                       last;
        logic [cws_pkg::WIN_W-1:0]  window;
        logic [cws_pkg::WIN_W-1:0]  threshold;
        logic [cws_pkg::BASE_W-1:0] next_start;
    } result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       wr_en;
    logic                       wr_index;
    logic [cws_pkg::FS_W-1:0]   wr_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 req_type;
    logic [cws_pkg::SEQ_W-1:0]  ack_seq;
    logic                       out_valid;
    logic                       out_stall;
    logic [cws_pkg::KIND_W-1:0] kind;
    logic [cws_pkg::SEQ_W-1:0]  seq;
    logic [cws_pkg::LEN_W-1:0]  length;
    logic                       resend;
    logic                       last;
    logic [cws_pkg::WIN_W-1:0]  window;
    logic [cws_pkg::WIN_W-1:0]  threshold;
    logic [cws_pkg::BASE_W-1:0] next_start;

    congestion_window_sender DUT (.*);

    // Predictor state, mirroring the block's own registers and status store.
    logic [1:0] pkt_state [PKT_MAX];
    int unsigned cfg_file_size;
    int unsigned win_base;
    int unsigned win_size;
    int unsigned slow_thr;
    int unsigned sent_in_round;
    int unsigned acks_in_round;
    int unsigned top_ack_next;
    bit          round_live;

    result_t expected_results[$];
    int          mismatches;
    int unsigned items_sent;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver stall, redrawn at every falling edge according to the phase.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic int unsigned packet_count();
        int unsigned t;
        t = (cfg_file_size + PKT_BYTES - 1) / PKT_BYTES;
        return (t > PKT_MAX) ? PKT_MAX : t;
    endfunction

    function automatic result_t make_result(input logic [cws_pkg::KIND_W-1:0] k,
                                            input int unsigned s,
                                            input int unsigned len,
                                            input bit rs, input bit lst);
        result_t r;
        r.kind       = k;
        r.seq        = s[cws_pkg::SEQ_W-1:0];
        r.length     = len[cws_pkg::LEN_W-1:0];
        r.resend     = rs;
        r.last       = lst;
        r.window     = win_size[cws_pkg::WIN_W-1:0];
        r.threshold  = slow_thr[cws_pkg::WIN_W-1:0];
        r.next_start = win_base[cws_pkg::BASE_W-1:0];
        return r;
    endfunction

    // Close the current round and return the kind of the closing result.
    function automatic logic [cws_pkg::KIND_W-1:0] close_window(input bit timed_out);
        int unsigned round_end;
        int unsigned first_gap;
        round_end = win_base + sent_in_round;
        first_gap = top_ack_next;
        if (first_gap == 0)
        begin
            first_gap = win_base;
            while (first_gap < round_end && first_gap < PKT_MAX
                   && pkt_state[first_gap] == cws_pkg::ST_ACKED)
                first_gap++;
        end
        round_live = 1'b0;
        if (timed_out || first_gap < round_end)
        begin
            win_base = first_gap;
            slow_thr = ((win_size >> 1) < 1) ? 1 : (win_size >> 1);
            win_size = 1;
            return cws_pkg::KIND_FAIL;
        end
        win_base = round_end;
        if (win_size < slow_thr)
            win_size = win_size << 1;
        else
            win_size++;
        if (win_size > WIN_MAX)
            win_size = WIN_MAX;
        return cws_pkg::KIND_OK;
    endfunction

    // Work out the results of one accepted request and queue them.
    task automatic predict_window_step(input logic [1:0] rt,
                                       input logic [cws_pkg::SEQ_W-1:0] aseq);
        int unsigned total;
        int unsigned id;
        int unsigned len;
        int          n;
        result_t     r;
        logic [cws_pkg::KIND_W-1:0] k;
        total = packet_count();
        if (rt == cws_pkg::REQ_SEND)
        begin
            if (round_live)
                expected_results.push_back(make_result(cws_pkg::KIND_IGN, 0, 0, 0, 1));
            else if (win_base >= total)
                expected_results.push_back(make_result(cws_pkg::KIND_DONE, 0, 0, 0, 1));
            else
            begin
                n = 0;
                for (int i = 0; i < win_size && i < WIN_MAX; i++)
                begin
                    id = win_base + i;
                    if (id >= total)
                        break;
                    len = PKT_BYTES;
                    if (id == total - 1)
                    begin
                        len = cfg_file_size - PKT_BYTES * id;
                        if (len > PKT_BYTES)
                            len = PKT_BYTES;
                    end
                    r = make_result(cws_pkg::KIND_DATA, id, len,
                                    pkt_state[id] != cws_pkg::ST_UNSENT, 0);
                    pkt_state[id] = cws_pkg::ST_WAIT;
                    expected_results.push_back(r);
                    n++;
                end
                sent_in_round = n;
                acks_in_round = 0;
                top_ack_next  = 0;
                round_live    = 1'b1;
                r = expected_results.pop_back();
                r.last = 1'b1;
                expected_results.push_back(r);
            end
        end
        else if (rt == cws_pkg::REQ_ACK)
        begin
            if (!round_live || aseq >= total)
                expected_results.push_back(make_result(cws_pkg::KIND_IGN, 0, 0, 0, 1));
            else
            begin
                pkt_state[aseq] = cws_pkg::ST_ACKED;
                if (aseq + 1 > top_ack_next)
                    top_ack_next = aseq + 1;
                acks_in_round++;
                if (acks_in_round >= sent_in_round)
                begin
                    k = close_window(1'b0);
                    expected_results.push_back(make_result(cws_pkg::KIND_ACK, aseq, 0, 0, 0));
                    expected_results.push_back(make_result(k, 0, 0, 0, 1));
                end
                else
                    expected_results.push_back(make_result(cws_pkg::KIND_ACK, aseq, 0, 0, 1));
            end
        end
        else if (rt == cws_pkg::REQ_TIMEOUT && round_live)
        begin
            k = close_window(1'b1);
            expected_results.push_back(make_result(k, 0, 0, 0, 1));
        end
        else
            expected_results.push_back(make_result(cws_pkg::KIND_IGN, 0, 0, 0, 1));
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind, seq, length, resend, last, window, threshold, next_start};
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d", kind));
            else
            begin
                want = expected_results.pop_front();
                if (got.kind != want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.seq != want.seq)
                    report_mismatch($sformatf("seq %0d, want %0d", got.seq, want.seq));
                if (got.length != want.length)
                    report_mismatch($sformatf("length %0d, want %0d",
                                              got.length, want.length));
                if (got.resend != want.resend)
                    report_mismatch($sformatf("resend %0b, want %0b",
                                              got.resend, want.resend));
                if (got.last != want.last)
                    report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
                if (got.window != want.window)
                    report_mismatch($sformatf("window %0d, want %0d",
                                              got.window, want.window));
                if (got.threshold != want.threshold)
                    report_mismatch($sformatf("threshold %0d, want %0d",
                                              got.threshold, want.threshold));
                if (got.next_start != want.next_start)
                    report_mismatch($sformatf("next_start %0d, want %0d",
                                              got.next_start, want.next_start));
            end
        end
    end

    // Take the request lines idle at the next falling edge.
    task automatic idle_input();
        @(negedge clk);
        in_valid <= 1'b0;
        req_type <= $urandom_range(3);
        ack_seq  <= $urandom_range(4095);
    endtask

    // Offer one request and hold it until the block takes it. The prediction is
    // made at the accepting edge, so the order against results stays exact.
    task automatic send_request(input logic [1:0] rt,
                                input logic [cws_pkg::SEQ_W-1:0] aseq);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            req_type <= $urandom_range(3);
            ack_seq  <= $urandom_range(4095);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        ack_seq  <= aseq;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        predict_window_step(rt, aseq);
    endtask

    // Wait until every expected result has arrived, then a little longer so the
    // back end has settled before anything else happens.
    task automatic drain_results();
        idle_input();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
    endtask

    // Register write while the block is idle. A file_size write starts a short
    // computation, which in_stall covers for the next request.
    task automatic write_register(input logic idx, input int unsigned value);
        drain_results();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value[cws_pkg::FS_W-1:0];
        @(negedge clk);
        wr_en    <= 1'b0;
        if (idx == cws_pkg::REG_FILE_SIZE)
            cfg_file_size = value & 32'h7F_FFFF;
        else
        begin
            slow_thr = value & 32'h7F;
        end
    endtask

    // Acknowledge the packets of the open round, in or out of order, with
    // an occasional lost ack.
    task automatic ack_round(input int unsigned first, input int unsigned count,
                             input bit shuffle, input int unsigned loss_pct);
        int unsigned order[$];
        int unsigned j;
        int unsigned tmp;
        for (int i = 0; i < count; i++)
            order.push_back(first + i);
        if (shuffle)
            for (int i = count - 1; i > 0; i--)
            begin
                j = $urandom_range(i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        foreach (order[i])
            if ($urandom_range(99) >= loss_pct)
                send_request(cws_pkg::REQ_ACK, order[i]);
    endtask

    // One full round: send, then ack it or let it time out.
    task automatic run_round(input bit shuffle, input int unsigned loss_pct);
        int unsigned base;
        int unsigned count;
        base = win_base;
        send_request(cws_pkg::REQ_SEND, $urandom_range(4095));
        count = round_live ? sent_in_round : 0;
        if (count != 0)
        begin
            ack_round(base, count, shuffle, loss_pct);
            if (round_live)
                send_request(cws_pkg::REQ_TIMEOUT, $urandom_range(4095));
        end
    endtask

    task automatic test_directed();
        write_register(cws_pkg::REG_FILE_SIZE, 5 * PKT_BYTES + 1);
        // Ack, timeout and the unused request type outside any round.
        send_request(cws_pkg::REQ_ACK, 0);
        send_request(cws_pkg::REQ_TIMEOUT, 12'hFFF);
        send_request(cws_pkg::REQ_NONE, 12'hFFF);
        // A clean round, then a send during an open round.
        send_request(cws_pkg::REQ_SEND, 0);
        send_request(cws_pkg::REQ_SEND, 0);
        send_request(cws_pkg::REQ_ACK, 12'hFFF);   // beyond the file
        send_request(cws_pkg::REQ_ACK, 0);
        // Round of two: one ack out of the window, then a timeout.
        send_request(cws_pkg::REQ_SEND, 0);
        send_request(cws_pkg::REQ_ACK, 4);
        send_request(cws_pkg::REQ_TIMEOUT, 0);
        // Go-back resend with a gap, closed by acks with a hole.
        send_request(cws_pkg::REQ_SEND, 0);
        run_round(1'b0, 0);
        run_round(1'b1, 30);
        for (int i = 0; i < 4; i++)
            run_round(1'b1, 0);
        // Past the end of the file.
        send_request(cws_pkg::REQ_SEND, 0);
    endtask

    task automatic test_empty_and_huge_file();
        write_register(cws_pkg::REG_FILE_SIZE, 0);
        send_request(cws_pkg::REQ_SEND, 0);
        write_register(cws_pkg::REG_FILE_SIZE, 23'h7F_FFFF);
        write_register(cws_pkg::REG_INIT_THR, 64);
        for (int i = 0; i < 4; i++)
            run_round(1'b1, 0);
        write_register(cws_pkg::REG_INIT_THR, 1);
        run_round(1'b0, 0);
        run_round(1'b1, 50);
    endtask

    task automatic test_random_traffic(input int unsigned items);
        int unsigned first_item;
        int unsigned pick;
        first_item = items_sent;
        while (items_sent - first_item < items)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                write_register(cws_pkg::REG_FILE_SIZE,
                               ($urandom_range(3) == 0) ? $urandom_range(23'h7F_FFFF)
                                                        : $urandom_range(40000));
            end
            else if (pick < 5)
            begin
                write_register(cws_pkg::REG_INIT_THR, $urandom_range(1, 64));
            end
            else if (pick < 85)
            begin
                run_round($urandom_range(1), ($urandom_range(1) == 0) ? 0 : 15);
            end
            else
            begin
                send_request($urandom_range(3), $urandom_range(4095));
            end
            if (win_base >= packet_count() && !round_live)
            begin
                send_request(cws_pkg::REQ_SEND, 0);
                write_register(cws_pkg::REG_FILE_SIZE, $urandom_range(1, 60000));
                // Restart the transfer view by acking nothing: base stays, so
                // grow the file beyond it when it sits past the end.
                if (win_base >= packet_count())
                    write_register(cws_pkg::REG_FILE_SIZE,
                                   (win_base + 1 + $urandom_range(40)) * PKT_BYTES
                                   - $urandom_range(1023));
            end
        end
    endtask

    initial
    begin
        mismatches     = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n     = 1'b0;
        wr_en     = 1'b0;
        wr_index  = 1'b0;
        wr_data   = '0;
        in_valid  = 1'b0;
        req_type  = cws_pkg::REQ_SEND;
        ack_seq   = '0;
        out_stall = 1'b0;
        for (int i = 0; i < PKT_MAX; i++)
            pkt_state[i] = cws_pkg::ST_UNSENT;
        cfg_file_size = 0;
        win_base      = 0;
        win_size      = 1;
        slow_thr      = cws_pkg::THR_RESET;
        sent_in_round = 0;
        acks_in_round = 0;
        top_ack_next  = 0;
        round_live    = 1'b0;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_empty_and_huge_file();
        test_random_traffic(40);
        send_idle_pct = 57;
        test_random_traffic(40);
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        test_random_traffic(40);
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        test_random_traffic(40);

        drain_results();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("congestion_window_sender regression: pass");
        else
            $display("congestion_window_sender regression: fail");
        $finish;
    end

    // Watchdog: generous bound for the clearing pass and the slowest stalled run.
    initial
    begin
        #8000000;
        $display("congestion_window_sender regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/cws_pkg.sv
rtl/core/cws_ram.sv
rtl/core/cws_front.sv
rtl/core/cws_queue.sv
rtl/core/cws_back.sv
rtl/core/congestion_window_sender.sv
bench/congestion_window_sender_tb.sv
